@@ rtl/sem_pkg.sv @@
// Shared types, constants and state codes of the Sobel edge magnitude block.
// Used by the stream interfaces and by every module of the block.
package sem_pkg;

    localparam int CH_W        = 8;
    localparam int NUM_CH      = 3;
    localparam int PIX_W       = NUM_CH * CH_W;
    localparam int FW_W        = 11;
    localparam int FH_W        = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 1;
    localparam int ROW_LIMIT   = 4096;
    localparam int ROW_W       = 12;
    localparam int GSUM_W      = 12;
    localparam int GRAD_W      = 10;
    localparam int SQ_W        = 20;
    localparam int SUM_W       = 21;
    localparam int RAD_W       = 16;
    localparam int REM_W       = 10;
    localparam int ROOT_STEPS  = 8;
    localparam int STEP_W      = 3;

    localparam logic [SUM_W-1:0] SAT_SUM  = SUM_W'(65280);
    localparam logic [CH_W-1:0]  SAT_EDGE = 8'hFF;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    typedef logic [PIX_W-1:0] rgb_t;
    typedef rgb_t [2:0] column_t;
    typedef column_t [2:0] window_t;

    typedef struct packed {
        logic [2:0] row_ok;
        logic [2:0] col_ok;
    } tap_mask_t;

    typedef struct packed {
        logic [NUM_CH-1:0][GRAD_W-1:0] abs_gx;
        logic [NUM_CH-1:0][GRAD_W-1:0] abs_gy;
    } grad_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        T_IDLE,
        T_PIX,
        T_FL0,
        T_FL1,
        T_FL2
    } ctrl_state_t;

    typedef enum logic [2:0] {
        M_IDLE,
        M_SQ,
        M_SUM,
        M_ROOT,
        M_DONE
    } mag_state_t;

endpackage

@@ rtl/sem_stream_if.sv @@
// Valid/ready stream interfaces for input pixels and result edge pixels.
// Depends on sem_pkg for the channel width.
interface sem_pixel_if import sem_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            mode;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;

    modport source (output valid, mode, red_in, green_in, blue_in, input ready);
    modport sink (input valid, mode, red_in, green_in, blue_in, output ready);
endinterface

interface sem_edge_if import sem_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red_edge;
    logic [CH_W-1:0] green_edge;
    logic [CH_W-1:0] blue_edge;
    logic            frame_end;

    modport source (output valid, red_edge, green_edge, blue_edge, frame_end, input ready);
    modport sink (input valid, red_edge, green_edge, blue_edge, frame_end, output ready);
endinterface

@@ rtl/sem_line_mem.sv @@
// Line store memory: upper and middle line side by side in one word.
// Synchronous registered read and one write port. Uses sem_pkg.
module sem_line_mem import sem_pkg::*; #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic               clk,
    input  logic               rd_en,
    input  logic [AW-1:0]      rd_addr,
    output logic [2*PIX_W-1:0] rd_data,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  logic [2*PIX_W-1:0] wr_data
);

    logic [2*PIX_W-1:0] mem [DEPTH];
    logic [2*PIX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/sem_grad.sv @@
// Masks the 3x3 window taps that lie outside the frame and forms the Sobel
// gradient magnitudes |Gx| and |Gy| of each color channel. Uses sem_pkg.
module sem_grad import sem_pkg::*; (
    input  window_t   taps,
    input  tap_mask_t mask,
    output grad_t     grad
);

    always_comb
    begin
        logic [2:0][2:0][CH_W-1:0] v;
        logic [GSUM_W-1:0] pos_x;
        logic [GSUM_W-1:0] neg_x;
        logic [GSUM_W-1:0] pos_y;
        logic [GSUM_W-1:0] neg_y;
        logic [GSUM_W-1:0] gx;
        logic [GSUM_W-1:0] gy;
        logic [GSUM_W-1:0] ax;
        logic [GSUM_W-1:0] ay;
        grad = '0;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    v[c][r] = (mask.col_ok[c] && mask.row_ok[r]) ?
                              taps[c][r][(NUM_CH-1-ch)*CH_W +: CH_W] : '0;
                end
            end
            pos_x = GSUM_W'(v[2][0]) + {3'b000, v[2][1], 1'b0} + GSUM_W'(v[2][2]);
            neg_x = GSUM_W'(v[0][0]) + {3'b000, v[0][1], 1'b0} + GSUM_W'(v[0][2]);
            pos_y = GSUM_W'(v[0][2]) + {3'b000, v[1][2], 1'b0} + GSUM_W'(v[2][2]);
            neg_y = GSUM_W'(v[0][0]) + {3'b000, v[1][0], 1'b0} + GSUM_W'(v[2][0]);
            gx = pos_x - neg_x;
            gy = pos_y - neg_y;
            ax = gx[GSUM_W-1] ? (GSUM_W'(0) - gx) : gx;
            ay = gy[GSUM_W-1] ? (GSUM_W'(0) - gy) : gy;
            grad.abs_gx[ch] = ax[GRAD_W-1:0];
            grad.abs_gy[ch] = ay[GRAD_W-1:0];
        end
    end

endmodule

@@ rtl/sem_mag.sv @@
// Magnitude unit: squares the gradients, then takes a rounded square root one
// bit per cycle for all three channels, and holds the result in the output
// register. Uses sem_pkg and the sem_edge_if stream interface.
module sem_mag import sem_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  grad_t        grad,
    input  logic         last,
    output logic         idle,
    sem_edge_if.source   edges
);

    mag_state_t state_reg;
    mag_state_t state_next;

    logic [NUM_CH-1:0][GRAD_W-1:0] ax_reg;
    logic [NUM_CH-1:0][GRAD_W-1:0] ay_reg;
    logic [NUM_CH-1:0][SQ_W-1:0]   sqx_reg;
    logic [NUM_CH-1:0][SQ_W-1:0]   sqy_reg;
    logic [NUM_CH-1:0][RAD_W-1:0]  rad_reg;
    logic [NUM_CH-1:0][REM_W-1:0]  rem_reg;
    logic [NUM_CH-1:0][CH_W-1:0]   root_reg;
    logic [NUM_CH-1:0]             sat_reg;
    logic [STEP_W-1:0]             step_reg;
    logic                          last_reg;

    logic [NUM_CH-1:0][CH_W-1:0]   edge_val;
    logic                          load_out;

    logic                          out_valid_reg;
    logic [NUM_CH-1:0][CH_W-1:0]   out_edge_reg;
    logic                          out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        load_out   = 1'b0;
        unique case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    state_next = M_SQ;
                end
            end
            M_SQ:
            begin
                state_next = M_SUM;
            end
            M_SUM:
            begin
                state_next = M_ROOT;
            end
            M_ROOT:
            begin
                if (step_reg == STEP_W'(ROOT_STEPS - 1))
                begin
                    state_next = M_DONE;
                end
            end
            M_DONE:
            begin
                if (!out_valid_reg || edges.ready)
                begin
                    load_out   = 1'b1;
                    state_next = M_IDLE;
                end
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (state_reg == M_SUM)
        begin
            step_reg <= '0;
        end
        else if (state_reg == M_ROOT)
        begin
            step_reg <= step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        logic [REM_W+1:0] shifted;
        logic [REM_W+1:0] trial;
        logic [SUM_W-1:0] sum;
        if (start && state_reg == M_IDLE)
        begin
            ax_reg   <= grad.abs_gx;
            ay_reg   <= grad.abs_gy;
            last_reg <= last;
        end
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            shifted = {rem_reg[ch], rad_reg[ch][RAD_W-1 -: 2]};
            trial   = {2'b00, root_reg[ch], 2'b01};
            sum     = SUM_W'(sqx_reg[ch]) + SUM_W'(sqy_reg[ch]);
            if (state_reg == M_SQ)
            begin
                sqx_reg[ch] <= SQ_W'(ax_reg[ch]) * SQ_W'(ax_reg[ch]);
                sqy_reg[ch] <= SQ_W'(ay_reg[ch]) * SQ_W'(ay_reg[ch]);
            end
            if (state_reg == M_SUM)
            begin
                rad_reg[ch]  <= sum[RAD_W-1:0];
                sat_reg[ch]  <= (sum > SAT_SUM);
                rem_reg[ch]  <= '0;
                root_reg[ch] <= '0;
            end
            if (state_reg == M_ROOT)
            begin
                rad_reg[ch] <= {rad_reg[ch][RAD_W-3:0], 2'b00};
                if (shifted >= trial)
                begin
                    rem_reg[ch]  <= REM_W'(shifted - trial);
                    root_reg[ch] <= {root_reg[ch][CH_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[ch]  <= shifted[REM_W-1:0];
                    root_reg[ch] <= {root_reg[ch][CH_W-2:0], 1'b0};
                end
            end
        end
    end

    // The remainder exceeds the root exactly when the value lies above n*n + n.
    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            if (sat_reg[ch])
            begin
                edge_val[ch] = SAT_EDGE;
            end
            else if (rem_reg[ch] > REM_W'(root_reg[ch]))
            begin
                edge_val[ch] = root_reg[ch] + 1'b1;
            end
            else
            begin
                edge_val[ch] = root_reg[ch];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (edges.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_edge_reg <= edge_val;
            out_last_reg <= last_reg;
        end
    end

    assign idle             = (state_reg == M_IDLE);
    assign edges.valid      = out_valid_reg;
    assign edges.red_edge   = out_edge_reg[0];
    assign edges.green_edge = out_edge_reg[1];
    assign edges.blue_edge  = out_edge_reg[2];
    assign edges.frame_end  = out_last_reg;

endmodule

@@ rtl/sobel_edge_magnitude_rgb_unit.sv @@
// Top level of the streaming 3x3 Sobel edge magnitude block for RGB pixels.
// Depends on sem_pkg, the stream interfaces, sem_line_mem, sem_grad and sem_mag.
//
// Pixels enter on the pixels channel in raster order; mode selects a pixel or
// a flush tick. Results leave on the edges channel in raster order, with
// frame_end set on the bottom-right pixel of a frame. The result of a pixel
// leaves once its lower-right neighbor has been accepted; after the last pixel
// of a frame, flush ticks drain the remaining width plus one results.
// The frame size is written through the cfg_write, cfg_index and cfg_data port
// while the block is idle, a rule on the user that the block does not enforce;
// a write restarts the frame. A pixel without a result reads the line store in
// T_IDLE and writes it in T_PIX. After a result transaction the next one also
// waits for the magnitude unit, busy in the gradient square stage, the sum
// stage, the bit-per-cycle square root and the output load, which waits while
// the receiver stalls; a bottom-row flush adds three line store reads first.
// At reset the frame size returns to 1024 by 1024 (width clamped to
// MAX_WIDTH) and all counters clear; the line store needs no clearing.
// When the receiver stalls, the result waits in the output register and one more
// transaction that gives a result is still taken; after that ready stays low.
module sobel_edge_magnitude_rgb_unit import sem_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                   clk,
    input  logic                   rst_n,
    sem_pixel_if.sink              pixels,
    sem_edge_if.source             edges,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int PW        = $clog2(MAX_WIDTH + 3);
    localparam int RESET_WM1 = ((MAX_WIDTH < 1024) ? MAX_WIDTH : 1024) - 1;
    localparam int RESET_HM1 = 1024 - 1;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    logic [CW-1:0]    wm1_reg;
    logic [ROW_W-1:0] hm1_reg;
    logic [CW-1:0]    wm1_cfg;
    logic [ROW_W-1:0] hm1_cfg;
    logic [FW_W-1:0]  fw_val;
    logic [FH_W-1:0]  fh_val;

    logic [CW-1:0]    icol_reg;
    logic [ROW_W-1:0] irow_reg;
    logic [CW-1:0]    ocol_reg;
    logic [ROW_W-1:0] orow_reg;
    logic [PW-1:0]    pend_reg;

    logic             job_emit_reg;
    logic             job_last_reg;
    tap_mask_t        job_mask_reg;
    logic [CW-1:0]    job_addr_reg;
    rgb_t             job_pix_reg;

    column_t          win_lo_reg;
    column_t          win_hi_reg;
    logic [2*PIX_W-1:0] fcol0_reg;
    logic [2*PIX_W-1:0] fcol1_reg;

    logic             accept;
    logic             is_flush;
    logic             at_start;
    logic [PW-1:0]    pend_inc;
    logic [PW-1:0]    pend_lim;
    logic             pix_emit;
    logic             fl_emit;
    logic             fl_line;
    logic             out_last;
    tap_mask_t        live_mask;
    logic [CW-1:0]    ocol_adv;
    logic [ROW_W-1:0] orow_adv;
    logic [CW-1:0]    icol_adv;
    logic [ROW_W-1:0] irow_adv;

    logic               mem_rd_en;
    logic [CW-1:0]      mem_rd_addr;
    logic [2*PIX_W-1:0] mem_rd_data;
    logic               mem_wr_en;
    logic [2*PIX_W-1:0] mem_wr_data;

    column_t          new_col;
    window_t          taps;
    tap_mask_t        tap_mask;
    logic             tap_last;
    grad_t            grad;
    logic             mag_start;
    logic             mag_idle;

    assign fw_val = cfg_data[FW_W-1:0];
    assign fh_val = cfg_data[FH_W-1:0];

    always_comb
    begin
        if (fw_val == '0)
        begin
            wm1_cfg = '0;
        end
        else if (int'(fw_val) > MAX_WIDTH)
        begin
            wm1_cfg = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            wm1_cfg = CW'(fw_val - 1'b1);
        end
        if (fh_val == '0)
        begin
            hm1_cfg = '0;
        end
        else if (int'(fh_val) > ROW_LIMIT)
        begin
            hm1_cfg = ROW_W'(ROW_LIMIT - 1);
        end
        else
        begin
            hm1_cfg = ROW_W'(fh_val - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wm1_reg <= CW'(RESET_WM1);
            hm1_reg <= ROW_W'(RESET_HM1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  wm1_reg <= wm1_cfg;
                REG_FRAME_HEIGHT: hm1_reg <= hm1_cfg;
            endcase
        end
    end

    assign accept    = pixels.valid && pixels.ready;
    assign is_flush  = (pixels.mode == MODE_FLUSH);
    assign at_start  = (icol_reg == '0) && (irow_reg == '0);
    assign pend_inc  = (at_start ? PW'(0) : pend_reg) + 1'b1;
    assign pend_lim  = PW'(wm1_reg) + PW'(2);
    assign pix_emit  = (pend_inc > pend_lim);
    assign fl_emit   = (pend_reg != '0) && at_start;
    assign fl_line   = (orow_reg == hm1_reg);
    assign out_last  = (orow_reg == hm1_reg) && (ocol_reg == wm1_reg);

    assign live_mask.row_ok = {orow_reg != hm1_reg, 1'b1, orow_reg != '0};
    assign live_mask.col_ok = {ocol_reg != wm1_reg, 1'b1, ocol_reg != '0};

    always_comb
    begin
        if (ocol_reg == wm1_reg)
        begin
            ocol_adv = '0;
            orow_adv = (orow_reg == hm1_reg) ? '0 : orow_reg + 1'b1;
        end
        else
        begin
            ocol_adv = ocol_reg + 1'b1;
            orow_adv = orow_reg;
        end
        if (icol_reg == wm1_reg)
        begin
            icol_adv = '0;
            irow_adv = (irow_reg == hm1_reg) ? '0 : irow_reg + 1'b1;
        end
        else
        begin
            icol_adv = icol_reg + 1'b1;
            irow_adv = irow_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            icol_reg <= '0;
            irow_reg <= '0;
            ocol_reg <= '0;
            orow_reg <= '0;
            pend_reg <= '0;
        end
        else if (cfg_write)
        begin
            icol_reg <= '0;
            irow_reg <= '0;
            ocol_reg <= '0;
            orow_reg <= '0;
            pend_reg <= '0;
        end
        else if (accept)
        begin
            if (!is_flush)
            begin
                icol_reg <= icol_adv;
                irow_reg <= irow_adv;
                pend_reg <= pix_emit ? pend_inc - 1'b1 : pend_inc;
                if (at_start)
                begin
                    ocol_reg <= '0;
                    orow_reg <= '0;
                end
                else if (pix_emit)
                begin
                    ocol_reg <= ocol_adv;
                    orow_reg <= orow_adv;
                end
            end
            else if (fl_emit)
            begin
                pend_reg <= pend_reg - 1'b1;
                ocol_reg <= ocol_adv;
                orow_reg <= orow_adv;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_emit_reg <= 1'b0;
        end
        else if (accept)
        begin
            job_emit_reg <= !is_flush && pix_emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_last_reg <= out_last;
            job_mask_reg <= live_mask;
            job_addr_reg <= is_flush ? ocol_reg : icol_reg;
            job_pix_reg  <= {pixels.red_in, pixels.green_in, pixels.blue_in};
        end
        if (state_reg == T_FL0)
        begin
            fcol0_reg <= mem_rd_data;
        end
        if (state_reg == T_FL1)
        begin
            fcol1_reg <= mem_rd_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        mem_rd_en   = 1'b0;
        mem_rd_addr = job_addr_reg;
        mem_wr_en   = 1'b0;
        mag_start   = 1'b0;
        unique case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = is_flush ? ocol_reg - 1'b1 : icol_reg;
                    if (!is_flush)
                    begin
                        state_next = T_PIX;
                    end
                    else if (fl_emit && fl_line)
                    begin
                        state_next = T_FL0;
                    end
                    else if (fl_emit)
                    begin
                        mag_start = 1'b1;
                    end
                end
            end
            T_PIX:
            begin
                mem_wr_en  = 1'b1;
                mag_start  = job_emit_reg;
                state_next = T_IDLE;
            end
            T_FL0:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = job_addr_reg;
                state_next  = T_FL1;
            end
            T_FL1:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = job_addr_reg + 1'b1;
                state_next  = T_FL2;
            end
            T_FL2:
            begin
                mag_start  = 1'b1;
                state_next = T_IDLE;
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    assign pixels.ready = (state_reg == T_IDLE) && mag_idle;

    assign new_col[0]  = mem_rd_data[2*PIX_W-1:PIX_W];
    assign new_col[1]  = mem_rd_data[PIX_W-1:0];
    assign new_col[2]  = job_pix_reg;
    assign mem_wr_data = {mem_rd_data[PIX_W-1:0], job_pix_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_lo_reg <= '0;
            win_hi_reg <= '0;
        end
        else if (state_reg == T_PIX)
        begin
            win_lo_reg <= win_hi_reg;
            win_hi_reg <= new_col;
        end
    end

    always_comb
    begin
        taps[0]  = win_lo_reg;
        taps[1]  = win_hi_reg;
        taps[2]  = '0;
        tap_mask = live_mask;
        tap_last = out_last;
        unique case (state_reg)
            T_PIX:
            begin
                taps[2]  = new_col;
                tap_mask = job_mask_reg;
                tap_last = job_last_reg;
            end
            T_FL2:
            begin
                taps[0]  = {rgb_t'(0), fcol0_reg[PIX_W-1:0], fcol0_reg[2*PIX_W-1:PIX_W]};
                taps[1]  = {rgb_t'(0), fcol1_reg[PIX_W-1:0], fcol1_reg[2*PIX_W-1:PIX_W]};
                taps[2]  = {rgb_t'(0), new_col[1], new_col[0]};
                tap_mask = job_mask_reg;
                tap_last = job_last_reg;
            end
            default:
            begin
                taps[2] = '0;
            end
        endcase
    end

    sem_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (job_addr_reg),
        .wr_data (mem_wr_data)
    );

    sem_grad u_grad (
        .taps (taps),
        .mask (tap_mask),
        .grad (grad)
    );

    sem_mag u_mag (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mag_start),
        .grad  (grad),
        .last  (tap_last),
        .idle  (mag_idle),
        .edges (edges)
    );

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mag_start |-> mag_idle)
        else $error("magnitude unit started while busy");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_wr_en && mem_rd_en))
        else $error("line store read and write in the same cycle");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= pend_lim)
        else $error("pending count above width plus one");

    a_flush_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_FL2) |-> ($past(state_reg) == T_FL1))
        else $error("bottom-row flush reads out of order");

endmodule
